// ===== design/tasp_pkg.sv =====
`default_nettype none

package tasp_pkg;

    // Field and register widths.
    localparam int unsigned DIM_W    = 14;
    localparam int unsigned LAYER_W  = 9;
    localparam int unsigned GAP_W    = 8;
    localparam int unsigned COORD_W  = 13;
    localparam int unsigned PLAYER_W = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 14;

    // Limits of the atlas geometry.
    localparam logic [DIM_W-1:0]   MAX_SIZE   = 14'd8192;
    localparam logic [LAYER_W-1:0] MAX_LAYERS = 9'd256;
    localparam logic [COORD_W-1:0] COORD_MAX  = 13'd8191;

    // Register defaults after reset.
    localparam logic [DIM_W-1:0]   ATLAS_SIZE_RST  = 14'd2048;
    localparam logic [LAYER_W-1:0] LAYER_COUNT_RST = 9'd16;
    localparam logic [GAP_W-1:0]   GAP_RST         = 8'd1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_BIG  = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATLAS_SIZE  = 2'd0,
        CFG_LAYER_COUNT = 2'd1,
        CFG_GAP         = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

// ===== design/texture_atlas_shelf_packer.sv =====
`default_nettype none

// Shelf packer for a square, multi-layer texture atlas.
// Input channel (in_valid / in_stall) carries one rectangle size per request,
// in placement order, plus a restart flag that clears the packing cursor.
// Output channel (out_valid / out_stall) returns one result per request:
// place_x, place_y, place_layer and status (placed, too large, atlas full).
// A failed placement leaves the cursor untouched, except for a restart.
// A request passes the input register, then the result register; a held
// result register can stall it between the two. Throughput is one request
// per cycle while out_stall is low. A single pass of adds and compares on
// the cursor registers forms the result register and the new cursor in the
// same edge.
// When out_stall holds the result register, the request in the input
// register waits and in_stall rises; both stages keep their contents.
// Reset clears both stages, the cursor (0, 0, layer 0, row height 0) and sets
// atlas_size to 2048, layer_count to 16 and gap to 1. The configuration port
// writes one register per cycle when cfg_we is high; indexes beyond gap are
// ignored. The user makes writes only while the block idles; not enforced.
module texture_atlas_shelf_packer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_we,
    input  wire logic [tasp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tasp_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [tasp_pkg::DIM_W-1:0]           rect_width,
    input  wire logic [tasp_pkg::DIM_W-1:0]           rect_height,
    input  wire logic                                 restart,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [tasp_pkg::COORD_W-1:0]              place_x,
    output logic [tasp_pkg::COORD_W-1:0]              place_y,
    output logic [tasp_pkg::PLAYER_W-1:0]             place_layer,
    output tasp_pkg::status_t                         status
);
    import tasp_pkg::*;

    // Configuration registers.
    logic [DIM_W-1:0]   atlas_size_reg;
    logic [LAYER_W-1:0] layer_count_reg;
    logic [GAP_W-1:0]   gap_reg;

    // Packing cursor.
    logic [DIM_W-1:0]   cursor_x_reg;
    logic [DIM_W-1:0]   cursor_y_reg;
    logic [LAYER_W-1:0] cursor_layer_reg;
    logic [DIM_W-1:0]   row_height_reg;
    logic [DIM_W-1:0]   cursor_x_next;
    logic [DIM_W-1:0]   cursor_y_next;
    logic [LAYER_W-1:0] cursor_layer_next;
    logic [DIM_W-1:0]   row_height_next;

    // Input stage.
    logic               in_valid_reg;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic               restart_reg;

    // Result stage.
    logic                 out_valid_reg;
    logic [COORD_W-1:0]   place_x_reg;
    logic [COORD_W-1:0]   place_y_reg;
    logic [PLAYER_W-1:0]  place_layer_reg;
    status_t              status_reg;
    logic [COORD_W-1:0]   place_x_next;
    logic [COORD_W-1:0]   place_y_next;
    logic [PLAYER_W-1:0]  place_layer_next;
    status_t              status_next;

    // Handshake control.
    logic out_free;
    logic fire;
    logic in_take;

    // Placement datapath.
    logic [DIM_W-1:0]   size;
    logic [LAYER_W-1:0] layers;
    logic [DIM_W-1:0]   base_x;
    logic [DIM_W-1:0]   base_y;
    logic [LAYER_W-1:0] base_z;
    logic [DIM_W-1:0]   base_rh;
    logic               too_big;
    logic [DIM_W:0]     end_x;
    logic               wrap_x;
    logic [15:0]        row_y;
    logic [15:0]        wrap_y;
    logic [DIM_W-1:0]   wrap_rh;
    logic [16:0]        end_y;
    logic               wrap_z;
    logic [DIM_W-1:0]   new_x;
    logic [15:0]        new_y;
    logic [LAYER_W:0]   new_z;
    logic               full;
    logic               placed;
    logic [15:0]        adv_x;

    // The result register frees up when it is empty or is taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && out_free;
    assign in_take  = in_valid && !in_stall;
    assign in_stall = in_valid_reg && !out_free;

    // Clamp the configuration to the supported range.
    assign size   = (atlas_size_reg > MAX_SIZE) ? MAX_SIZE : atlas_size_reg;
    assign layers = (layer_count_reg > MAX_LAYERS) ? MAX_LAYERS : layer_count_reg;

    // A restart starts from an empty atlas.
    assign base_x  = restart_reg ? '0 : cursor_x_reg;
    assign base_y  = restart_reg ? '0 : cursor_y_reg;
    assign base_z  = restart_reg ? '0 : cursor_layer_reg;
    assign base_rh = restart_reg ? '0 : row_height_reg;

    assign too_big = (width_reg > size) || (height_reg > size);

    // Wrap to a new row when the rectangle does not fit across.
    assign end_x   = {1'b0, base_x} + {1'b0, width_reg};
    assign wrap_x  = end_x > {1'b0, size};
    assign row_y   = {2'b00, base_y} + {2'b00, base_rh} + {8'd0, gap_reg};
    assign wrap_y  = wrap_x ? row_y : {2'b00, base_y};
    assign wrap_rh = wrap_x ? '0 : base_rh;

    // Move to the next layer when the rectangle does not fit down.
    assign end_y   = {1'b0, wrap_y} + {3'b000, height_reg};
    assign wrap_z  = end_y > {3'b000, size};
    assign new_x   = (wrap_x || wrap_z) ? '0 : base_x;
    assign new_y   = wrap_z ? '0 : wrap_y;
    assign new_z   = {1'b0, base_z} + {{LAYER_W{1'b0}}, wrap_z};
    assign full    = new_z >= {1'b0, layers};
    assign placed  = !too_big && !full;
    assign adv_x   = {2'b00, new_x} + {2'b00, width_reg} + {8'd0, gap_reg};

    // Result fields; coordinates saturate for zero-sized rectangles at the edge.
    always_comb
    begin
        place_x_next     = '0;
        place_y_next     = '0;
        place_layer_next = '0;
        if (too_big)
        begin
            status_next = STATUS_TOO_BIG;
        end
        else if (full)
        begin
            status_next = STATUS_FULL;
        end
        else
        begin
            status_next      = STATUS_OK;
            place_x_next     = (new_x > {1'b0, COORD_MAX}) ? COORD_MAX : new_x[COORD_W-1:0];
            place_y_next     = (new_y > {3'b000, COORD_MAX}) ? COORD_MAX
                                                            : new_y[COORD_W-1:0];
            place_layer_next = new_z[PLAYER_W-1:0];
        end
    end

    // Cursor update: a placement advances it, a failure keeps it (after restart).
    always_comb
    begin
        if (placed)
        begin
            cursor_x_next     = adv_x[DIM_W-1:0];
            cursor_y_next     = new_y[DIM_W-1:0];
            cursor_layer_next = new_z[LAYER_W-1:0];
            row_height_next   = (height_reg > wrap_rh) ? height_reg : wrap_rh;
        end
        else
        begin
            cursor_x_next     = base_x;
            cursor_y_next     = base_y;
            cursor_layer_next = base_z;
            row_height_next   = base_rh;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_size_reg  <= ATLAS_SIZE_RST;
            layer_count_reg <= LAYER_COUNT_RST;
            gap_reg         <= GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ATLAS_SIZE:  atlas_size_reg  <= cfg_data[DIM_W-1:0];
                CFG_LAYER_COUNT: layer_count_reg <= cfg_data[LAYER_W-1:0];
                CFG_GAP:         gap_reg         <= cfg_data[GAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            width_reg   <= rect_width;
            height_reg  <= rect_height;
            restart_reg <= restart;
        end
    end

    // Cursor and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            cursor_layer_reg <= '0;
            row_height_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                cursor_x_reg     <= cursor_x_next;
                cursor_y_reg     <= cursor_y_next;
                cursor_layer_reg <= cursor_layer_next;
                row_height_reg   <= row_height_next;
                out_valid_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            place_x_reg     <= place_x_next;
            place_y_reg     <= place_y_next;
            place_layer_reg <= place_layer_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign place_x     = place_x_reg;
    assign place_y     = place_y_reg;
    assign place_layer = place_layer_reg;
    assign status      = status_reg;

`ifndef SYNTH
    // A failed request reports no position.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |->
            (place_x == '0 && place_y == '0 && place_layer == '0))
        else $error("failed placement reports a nonzero position");

    // The stored layer always names a usable layer.
    a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_layer_reg < MAX_LAYERS)
        else $error("cursor layer beyond the last layer");

    // A placement leaves the row cursor inside the atlas.
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && placed) |=> (cursor_y_reg <= MAX_SIZE))
        else $error("row cursor left the atlas");

    // The input stage waits only while the result stage is held.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled with a free result register");
`endif

endmodule

`default_nettype wire

// ===== tb/shelf_placement_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port of the shelf packer, predicts
// every placement and compares each result with the oldest prediction.
module shelf_placement_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire logic [tasp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tasp_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                             in_valid,
    input  wire logic                             in_stall,
    input  wire logic [tasp_pkg::DIM_W-1:0]       rect_width,
    input  wire logic [tasp_pkg::DIM_W-1:0]       rect_height,
    input  wire logic                             restart,

    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [tasp_pkg::COORD_W-1:0]     place_x,
    input  wire logic [tasp_pkg::COORD_W-1:0]     place_y,
    input  wire logic [tasp_pkg::PLAYER_W-1:0]    place_layer,
    input  tasp_pkg::status_t                     status,

    output int                                    fail_count,
    output int                                    pending
);

    import tasp_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [PLAYER_W-1:0] layer;
        status_t             st;
    } placement_t;

    // Mirror of the atlas registers.
    logic [DIM_W-1:0]   atlas_size_r;
    logic [LAYER_W-1:0] layer_count_r;
    logic [GAP_W-1:0]   gap_r;

    // Mirror of the packing cursor.
    logic [DIM_W-1:0]   cur_x;
    logic [DIM_W-1:0]   cur_y;
    logic [LAYER_W-1:0] cur_layer;
    logic [DIM_W-1:0]   shelf_height;

    placement_t placements_due[$];
    int         errors;

    // Places one rectangle on the mirrored cursor and returns the placement.
    task automatic place_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic clear, output placement_t res);
        int unsigned size;
        int unsigned layers;
        int unsigned nx;
        int unsigned ny;
        int unsigned nz;
        int unsigned nrh;
        res = '0;
        res.st = STATUS_OK;
        if (clear)
        begin
            cur_x = '0;
            cur_y = '0;
            cur_layer = '0;
            shelf_height = '0;
        end
        size = 32'((atlas_size_r > MAX_SIZE) ? MAX_SIZE : atlas_size_r);
        layers = 32'((layer_count_r > MAX_LAYERS) ? MAX_LAYERS : layer_count_r);
        if (w > size || h > size)
        begin
            res.st = STATUS_TOO_BIG;
            return;
        end
        nx = 32'(cur_x);
        ny = 32'(cur_y);
        nz = 32'(cur_layer);
        nrh = 32'(shelf_height);
        // Wrap to a new shelf when the rectangle does not fit across.
        if (nx + w > size)
        begin
            ny = ny + nrh + gap_r;
            nx = 0;
            nrh = 0;
        end
        // Move to the next layer when it does not fit down; the shelf
        // height is kept on purpose.
        if (ny + h > size)
        begin
            nx = 0;
            ny = 0;
            nz = nz + 1;
        end
        if (nz >= layers)
        begin
            res.st = STATUS_FULL;
            return;
        end
        res.x = (nx > COORD_MAX) ? COORD_MAX : nx[COORD_W-1:0];
        res.y = (ny > COORD_MAX) ? COORD_MAX : ny[COORD_W-1:0];
        res.layer = nz[PLAYER_W-1:0];
        cur_x = DIM_W'(nx + w + gap_r);
        cur_y = DIM_W'(ny);
        cur_layer = LAYER_W'(nz);
        shelf_height = (h > nrh) ? h : DIM_W'(nrh);
    endtask

    task automatic flag_mismatch(input string what, input placement_t due,
                                 input placement_t got);
        if (errors < 10)
        begin
            $write("placement error at %0t: %s, expected x=%0d y=%0d layer=%0d status=%0d",
                   $time, what, due.x, due.y, due.layer, due.st);
            $display(", got x=%0d y=%0d layer=%0d status=%0d",
                     got.x, got.y, got.layer, got.st);
        end
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        placement_t due;
        placement_t got;
        if (!rst_n)
        begin
            atlas_size_r = ATLAS_SIZE_RST;
            layer_count_r = LAYER_COUNT_RST;
            gap_r = GAP_RST;
            cur_x = '0;
            cur_y = '0;
            cur_layer = '0;
            shelf_height = '0;
            placements_due.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // Register writes.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ATLAS_SIZE:  atlas_size_r = cfg_data[DIM_W-1:0];
                    CFG_LAYER_COUNT: layer_count_r = cfg_data[LAYER_W-1:0];
                    CFG_GAP:         gap_r = cfg_data[GAP_W-1:0];
                    default:         ;
                endcase
            end

            // Accepted result against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got = {place_x, place_y, place_layer, status};
                if (placements_due.size() == 0)
                begin
                    due = '0;
                    flag_mismatch("result with no request waiting", due, got);
                end
                else
                begin
                    due = placements_due.pop_front();
                    if (got !== due)
                        flag_mismatch("wrong placement", due, got);
                end
            end

            // Accepted request.
            if (in_valid && !in_stall)
            begin
                place_rect(rect_width, rect_height, restart, due);
                placements_due.push_back(due);
            end

            fail_count <= errors;
            pending <= placements_due.size();
        end
    end

endmodule

// ===== tb/tb_texture_atlas_shelf_packer.sv =====
`timescale 1ns / 100ps

module tb_texture_atlas_shelf_packer;

    import tasp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [DIM_W-1:0]      rect_width = '0;
    logic [DIM_W-1:0]      rect_height = '0;
    logic                  restart = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COORD_W-1:0]    place_x;
    logic [COORD_W-1:0]    place_y;
    logic [PLAYER_W-1:0]   place_layer;
    status_t               status;

    int fail_count;
    int pending;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned size_eff = ATLAS_SIZE_RST;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    texture_atlas_shelf_packer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .place_x     (place_x),
        .place_y     (place_y),
        .place_layer (place_layer),
        .status      (status)
    );

    shelf_placement_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .place_x     (place_x),
        .place_y     (place_y),
        .place_layer (place_layer),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always #6 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stall, plus one long hold-off so the pipe fills up.
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offers one request and returns at the edge that accepts it.
    task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic clear);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rect_width <= w;
        rect_height <= h;
        restart <= clear;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering and waits until every placement has come back.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Writes all three atlas registers while the block is idle.
    task automatic set_atlas(input logic [CFG_DATA_W-1:0] size,
                             input logic [CFG_DATA_W-1:0] layers,
                             input logic [CFG_DATA_W-1:0] g, input bit spare);
        drain();
        write_reg(CFG_ATLAS_SIZE, size);
        write_reg(CFG_LAYER_COUNT, layers);
        write_reg(CFG_GAP, g);
        // A write to the unused index must change nothing.
        if (spare)
            write_reg(CFG_SPARE, '1);
        cfg_we <= 1'b0;
        size_eff = 32'((size > MAX_SIZE) ? MAX_SIZE : size);
    endtask

    // Mostly sizes that fit a few per shelf, some edge sizes and some noise.
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned eff);
        int unsigned sel;
        int unsigned quarter;
        sel = $urandom_range(0, 99);
        quarter = (eff / 4 == 0) ? 1 : eff / 4;
        if (sel < 60)
            return DIM_W'($urandom_range(0, quarter));
        else if (sel < 80)
            return DIM_W'($urandom_range(0, eff));
        else if (sel < 85)
            return DIM_W'(eff);
        else if (sel < 90)
            return '0;
        else if (sel < 95)
            return DIM_W'(eff + 1);
        return DIM_W'($urandom_range(0, 16383));
    endfunction

    task automatic run_random(input int count, input int restart_pct);
        for (int i = 0; i < count; i++)
        begin
            send_rect(pick_dim(size_eff), pick_dim(size_eff),
                      $urandom_range(0, 99) < restart_pct);
        end
    endtask

    initial
    begin
        send_idle_pct = 29;
        recv_idle_pct = 61;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: first placement, layer wrap, oversize with and
        // without restart.
        send_rect(14'd0, 14'd0, 1'b1);
        send_rect(14'd2048, 14'd2048, 1'b0);
        send_rect(14'd2049, 14'd5, 1'b0);
        send_rect(14'd16383, 14'd16383, 1'b1);
        send_rect(14'd8192, 14'd1, 1'b0);
        send_rect(14'd7, 14'd9, 1'b0);

        // Oversized atlas register acts as the largest atlas, one layer, no gap:
        // full-size rectangle, zero-sized ones at the far edges, atlas full.
        set_atlas(14'd16383, 14'd1, 14'd0, 1'b0);
        send_rect(14'd8192, 14'd8192, 1'b1);
        send_rect(14'd0, 14'd0, 1'b0);
        send_rect(14'd1, 14'd1, 1'b0);
        send_rect(14'd5, 14'd0, 1'b0);
        send_rect(14'd0, 14'd8192, 1'b0);
        send_rect(14'd1, 14'd1, 1'b1);

        // Empty atlas with no layers: only zero sizes fit, and they find it full.
        set_atlas(14'd0, 14'd0, 14'd255, 1'b1);
        send_rect(14'd0, 14'd0, 1'b1);
        send_rect(14'd1, 14'd0, 1'b0);
        send_rect(14'd0, 14'd1, 1'b1);

        // Oversized layer register, widest gap.
        set_atlas(14'd100, 14'd511, 14'd255, 1'b0);
        send_rect(14'd10, 14'd10, 1'b1);
        send_rect(14'd10, 14'd10, 1'b0);
        send_rect(14'd100, 14'd100, 1'b0);
        send_rect(14'd101, 14'd3, 1'b0);

        // Random phases, sender idling less than receiver.
        set_atlas(14'd64, 14'd4, 14'd1, 1'b0);
        run_random(290, 3);
        set_atlas(14'd8192, 14'd256, 14'd0, 1'b0);
        run_random(290, 2);

        // Receiver idling less than sender; the tiny atlas with the widest
        // gap walks through all 256 layers.
        send_idle_pct = 61;
        recv_idle_pct = 29;
        set_atlas(14'd16, 14'd256, 14'd255, 1'b0);
        run_random(330, 0);
        set_atlas(14'd2048, 14'd16, 14'd1, 1'b0);
        run_random(270, 3);

        // No idling; one long receiver hold-off while requests keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_atlas(14'd1, 14'd1, 14'd0, 1'b0);
        hold_go <= 1'b1;
        run_random(200, 10);
        set_atlas(14'd5000, 14'd300, 14'd37, 1'b0);
        run_random(370, 3);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
